// ===== design/wsdf_pkg.sv =====
package wsdf_pkg;

	localparam int MAX_FRAME_BYTES_DEF = 4096;

	typedef enum logic [2:0] {
		PH_HDR0,
		PH_HDR1,
		PH_EXT16,
		PH_EXT64,
		PH_MASK,
		PH_PAYLOAD
	} phase_t;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_TOO_LONG  = 2'd1;
	localparam logic [1:0] ST_TRUNCATED = 2'd2;
	localparam logic [1:0] ST_CLOSED    = 2'd3;

	localparam logic [1:0] RP_NONE  = 2'd0;
	localparam logic [1:0] RP_PONG  = 2'd1;
	localparam logic [1:0] RP_CLOSE = 2'd2;

	localparam logic [3:0] OP_CLOSE = 4'h8;
	localparam logic [3:0] OP_PING  = 4'h9;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	localparam logic [2:0] EXT16_BYTES = 3'd2;
	// eight bytes: the 3-bit count wraps to zero on the last one
	localparam logic [2:0] EXT64_BYTES = 3'd0;
	localparam logic [2:0] MASK_BYTES  = 3'd4;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       stream_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        has_data;
		logic        last;
		logic [3:0]  frame_opcode;
		logic        fin_flag;
		logic [12:0] frame_length;
		logic [1:0]  status;
		logic [1:0]  reply_kind;
	} out_item_t;

endpackage

// ===== design/wsdf_if.sv =====
interface wsdf_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/wsdf_parser.sv =====
module wsdf_parser #(
	parameter int MAX_FRAME_BYTES = wsdf_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  wsdf_pkg::in_item_t  item,
	output logic                has_res,
	output wsdf_pkg::out_item_t res
);
	import wsdf_pkg::*;

	localparam int LW = $clog2(MAX_FRAME_BYTES + 1);
	localparam logic [LW-1:0] MAX_L = LW'(MAX_FRAME_BYTES);

	phase_t          phase_q, phase_n;
	logic            fin_q, fin_n;
	logic [3:0]      op_q, op_n;
	logic            mask_q, mask_n;
	logic [LW-1:0]   len_q, len_n;
	logic            ovf_q, ovf_n;
	logic [2:0]      cnt_q, cnt_n;
	logic [31:0]     key_q, key_n;
	logic [LW-1:0]   left_q, left_n;
	logic [1:0]      idx_q, idx_n;
	logic            closed_q, closed_n;

	logic            len_done;
	logic            empty_done;
	logic [7:0]      b;
	logic [2:0]      cnt_inc;
	logic [2:0]      need;
	logic [LW:0]     shifted;

	// shift a byte into the length, keeping a sticky flag for bits pushed out
	function automatic logic [LW:0] shift_in(input logic [LW-1:0] len, input logic ovf,
			input logic [7:0] nb);
		logic [LW+7:0] w;
		w = {len, nb};
		return {ovf | (|w[LW+7:LW]), w[LW-1:0]};
	endfunction

	function automatic logic [1:0] frame_reply(input logic [3:0] op);
		logic [1:0] r;
		r = RP_NONE;
		if (op == OP_PING) r = RP_PONG;
		else if (op == OP_CLOSE) r = RP_CLOSE;
		return r;
	endfunction

	always_comb begin
		phase_n    = phase_q;
		fin_n      = fin_q;
		op_n       = op_q;
		mask_n     = mask_q;
		len_n      = len_q;
		ovf_n      = ovf_q;
		cnt_n      = cnt_q;
		key_n      = key_q;
		left_n     = left_q;
		idx_n      = idx_q;
		closed_n   = closed_q;
		has_res    = 1'b0;
		res        = '0;
		len_done   = 1'b0;
		empty_done = 1'b0;
		b          = item.rx_byte;
		cnt_inc    = cnt_q + 3'd1;
		need       = (phase_q == PH_EXT16) ? EXT16_BYTES : EXT64_BYTES;
		shifted    = '0;

		priority if (closed_q) begin
			has_res    = 1'b1;
			res.last   = 1'b1;
			res.status = ST_CLOSED;
		end else if (item.stream_end) begin
			if (phase_q != PH_HDR0) begin
				phase_n          = PH_HDR0;
				has_res          = 1'b1;
				res.last         = 1'b1;
				res.frame_opcode = op_q;
				res.fin_flag     = fin_q;
				res.status       = ST_TRUNCATED;
			end
		end else begin
			unique case (phase_q)
				PH_HDR0: begin
					fin_n   = b[7];
					op_n    = b[3:0];
					phase_n = PH_HDR1;
				end
				PH_HDR1: begin
					mask_n = b[7];
					key_n  = '0;
					cnt_n  = '0;
					len_n  = '0;
					ovf_n  = 1'b0;
					if (b[6:0] == LEN_EXT16) begin
						phase_n = PH_EXT16;
					end else if (b[6:0] == LEN_EXT64) begin
						phase_n = PH_EXT64;
					end else begin
						shifted  = shift_in('0, 1'b0, {1'b0, b[6:0]});
						ovf_n    = shifted[LW];
						len_n    = shifted[LW-1:0];
						len_done = 1'b1;
					end
				end
				PH_EXT16, PH_EXT64: begin
					shifted = shift_in(len_q, ovf_q, b);
					ovf_n   = shifted[LW];
					len_n   = shifted[LW-1:0];
					cnt_n   = cnt_inc;
					if (cnt_inc == need) len_done = 1'b1;
				end
				PH_MASK: begin
					key_n = {key_q[23:0], b};
					cnt_n = cnt_inc;
					if (cnt_inc == MASK_BYTES) begin
						cnt_n = '0;
						if (left_q == '0) empty_done = 1'b1;
						else phase_n = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					idx_n = idx_q + 2'd1;
					if (left_q != '0) left_n = left_q - LW'(1);
					has_res          = 1'b1;
					res.data_byte    = b ^ key_q[{~idx_q, 3'b000} +: 8];
					res.has_data     = 1'b1;
					res.frame_opcode = op_q;
					res.fin_flag     = fin_q;
					res.frame_length = 13'(len_q);
					res.status       = ST_OK;
					if (left_n == '0) begin
						res.last       = 1'b1;
						res.reply_kind = frame_reply(op_q);
						if (op_q == OP_CLOSE) closed_n = 1'b1;
						phase_n = PH_HDR0;
					end
				end
				default: phase_n = PH_HDR0;
			endcase
		end

		if (len_done) begin
			if (ovf_n || len_n > MAX_L) begin
				phase_n          = PH_HDR0;
				has_res          = 1'b1;
				res.last         = 1'b1;
				res.frame_opcode = op_q;
				res.fin_flag     = fin_q;
				res.status       = ST_TOO_LONG;
			end else begin
				left_n = len_n;
				idx_n  = '0;
				cnt_n  = '0;
				if (mask_n) phase_n = PH_MASK;
				else if (len_n == '0) empty_done = 1'b1;
				else phase_n = PH_PAYLOAD;
			end
		end

		if (empty_done) begin
			phase_n          = PH_HDR0;
			has_res          = 1'b1;
			res.last         = 1'b1;
			res.frame_opcode = op_q;
			res.fin_flag     = fin_q;
			res.status       = ST_OK;
			res.reply_kind   = frame_reply(op_q);
			if (op_q == OP_CLOSE) closed_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HDR0;
			fin_q    <= 1'b0;
			op_q     <= '0;
			mask_q   <= 1'b0;
			len_q    <= '0;
			ovf_q    <= 1'b0;
			cnt_q    <= '0;
			key_q    <= '0;
			left_q   <= '0;
			idx_q    <= '0;
			closed_q <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_n;
			fin_q    <= fin_n;
			op_q     <= op_n;
			mask_q   <= mask_n;
			len_q    <= len_n;
			ovf_q    <= ovf_n;
			cnt_q    <= cnt_n;
			key_q    <= key_n;
			left_q   <= left_n;
			idx_q    <= idx_n;
			closed_q <= closed_n;
		end
	end

	a_closed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		closed_q |=> closed_q)
		else $error("closed flag dropped");

	a_payload_left: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> left_q != '0)
		else $error("payload phase with no bytes left");

	a_nonlast_is_data: assert property (@(posedge clk) disable iff (!arst_n)
		step && has_res && !res.last |-> res.has_data && phase_q == PH_PAYLOAD)
		else $error("non-final result outside payload");

endmodule

// ===== design/websocket_frame_deframer_top.sv =====
// Receive-side frame parser for the WebSocket wire format. One request on rx carries one
// received byte or a stream-end marker; each payload byte leaves on res unmasked, and a
// frame with no payload, a too-long length, a truncated stream or any traffic after a
// close gives a single result with last set. Throughput is one request per clock: the
// parse state updates combinationally between the input register and the result register,
// so a new byte is taken every cycle while res is drained. Header bytes that do not end an
// empty or too-long frame, and a stream end between frames, produce no result. The input
// stage holds its byte when the result register is full and not being taken, so rx.ready
// follows res.ready with one register of slack.
module websocket_frame_deframer_top #(
	parameter int MAX_FRAME_BYTES = wsdf_pkg::MAX_FRAME_BYTES_DEF
) (
	input logic   clk,
	input logic   arst_n,
	wsdf_if.sink   rx,
	wsdf_if.source res
);
	import wsdf_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      out_valid_q;
	out_item_t out_item_q;
	logic      adv;
	logic      has_res;
	out_item_t res_item;

	assign adv      = valid_s1 && (!out_valid_q || res.ready);
	assign rx.ready = !valid_s1 || adv;

	wsdf_parser #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.item    (item_s1),
		.has_res (has_res),
		.res     (res_item)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) item_s1 <= rx.data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= has_res;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && has_res) out_item_q <= res_item;
	end

	assign res.valid = out_valid_q;
	assign res.data  = out_item_q;

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(item_s1))
		else $error("stalled input stage lost its byte");

endmodule
